// ===== src/assert_macros.svh =====
// Assertion macros shared by the display window pixel writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check at every clock edge outside reset.
`define DWPW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Check at every clock edge, reset included.
`define DWPW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define DWPW_ASSERT(lbl, prop)
`define DWPW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/dwpw_pkg.sv =====
// Types and constants of the display window pixel writer.
package dwpw_pkg;

  localparam int unsigned MAX_BYTES   = 11;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned PIXEL_BYTES = 3;
  localparam int unsigned AREA_W      = 21;

  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2a;
  localparam logic [7:0] CMD_PAGE_ADDR    = 8'h2b;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2c;

  localparam logic [AREA_W-1:0] COUNT_MAX = {AREA_W{1'b1}};

  localparam logic [10:0] PANEL_WIDTH_RST  = 11'd320;
  localparam logic [10:0] PANEL_HEIGHT_RST = 11'd480;

  // Input item command codes
  localparam logic ITEM_WINDOW = 1'b0;
  localparam logic ITEM_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    REG_PANEL_WIDTH   = 2'd0,
    REG_PANEL_HEIGHT  = 2'd1,
    REG_COLUMN_OFFSET = 2'd2,
    REG_ROW_OFFSET    = 2'd3
  } dwpw_reg_t;

  typedef struct packed {
    logic [10:0] panel_width;
    logic [10:0] panel_height;
    logic [15:0] column_offset;
    logic [15:0] row_offset;
  } dwpw_cfg_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } dwpw_byte_t;

  typedef struct packed {
    logic                              load;
    logic [CNT_W-1:0]                  count;
    dwpw_byte_t [MAX_BYTES-1:0]        bytes;
  } dwpw_burst_t;

endpackage

// ===== src/dwpw_cfg_regs.sv =====
// Configuration register file of the display window pixel writer.
module dwpw_cfg_regs
  import dwpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output dwpw_cfg_t   cfg
);

  dwpw_cfg_t cfg_r;
  dwpw_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (dwpw_reg_t'(cfg_index))
        REG_PANEL_WIDTH:   cfg_nxt.panel_width   = cfg_wdata[10:0];
        REG_PANEL_HEIGHT:  cfg_nxt.panel_height  = cfg_wdata[10:0];
        REG_COLUMN_OFFSET: cfg_nxt.column_offset = cfg_wdata;
        REG_ROW_OFFSET:    cfg_nxt.row_offset    = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width   <= PANEL_WIDTH_RST;
      cfg_r.panel_height  <= PANEL_HEIGHT_RST;
      cfg_r.column_offset <= '0;
      cfg_r.row_offset    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/dwpw_format.sv =====
// Input register, window check, area count and byte burst formatting.
`include "assert_macros.svh"
module dwpw_format
  import dwpw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dwpw_cfg_t          cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [15:0] in_x_start,
  input  logic signed [15:0] in_y_start,
  input  logic signed [15:0] in_x_end,
  input  logic signed [15:0] in_y_end,
  input  logic [15:0]        in_pixel_rgb565,
  input  logic               ser_free,
  output dwpw_burst_t        burst
);

  logic              a_valid_r;
  logic              cmd_r;
  logic [15:0]       xs_r;
  logic [15:0]       ys_r;
  logic [15:0]       xe_r;
  logic [15:0]       ye_r;
  logic [15:0]       pix_r;
  logic [AREA_W-1:0] pix_left_r;
  logic [AREA_W-1:0] pix_left_nxt;

  logic              win_ok;
  logic              produce;
  logic              a_move;
  logic [10:0]       dx;
  logic [10:0]       dy;
  logic [21:0]       area;
  logic [AREA_W-1:0] area_sat;
  logic [15:0]       col_s;
  logic [15:0]       col_e;
  logic [15:0]       row_s;
  logic [15:0]       row_e;

  always_comb begin
    win_ok = !(($signed(xe_r) < $signed(xs_r)) || ($signed(ye_r) < $signed(ys_r)) ||
               xs_r[15] || ys_r[15] ||
               ($signed(xe_r) >= $signed({5'b0, cfg.panel_width})) ||
               ($signed(ye_r) >= $signed({5'b0, cfg.panel_height})));
    // A passing window has extents of 1 to 2047, so 11 bits carry them exactly
    dx       = xe_r[10:0] - xs_r[10:0] + 11'd1;
    dy       = ye_r[10:0] - ys_r[10:0] + 11'd1;
    area     = {11'b0, dx} * {11'b0, dy};
    area_sat = (area[21]) ? COUNT_MAX : area[AREA_W-1:0];
    col_s    = xs_r + cfg.column_offset;
    col_e    = xe_r + cfg.column_offset;
    row_s    = ys_r + cfg.row_offset;
    row_e    = ye_r + cfg.row_offset;

    produce  = (cmd_r == ITEM_PIXEL) ? (pix_left_r != '0) : win_ok;
    a_move   = a_valid_r && (!produce || ser_free);
    in_ready = !a_valid_r || a_move;

    burst       = '0;
    burst.load  = a_valid_r && produce && ser_free;
    if (cmd_r == ITEM_PIXEL) begin
      burst.count    = CNT_W'(PIXEL_BYTES);
      burst.bytes[0] = '{value: {pix_r[15:11], pix_r[15], 2'b00}, is_data: 1'b1, last: 1'b0};
      burst.bytes[1] = '{value: {pix_r[10:5], 2'b00},             is_data: 1'b1, last: 1'b0};
      burst.bytes[2] = '{value: {pix_r[4:0], pix_r[4], 2'b00},    is_data: 1'b1, last: 1'b1};
    end else begin
      burst.count     = CNT_W'(MAX_BYTES);
      burst.bytes[0]  = '{value: CMD_COLUMN_ADDR,  is_data: 1'b0, last: 1'b0};
      burst.bytes[1]  = '{value: col_s[15:8],      is_data: 1'b1, last: 1'b0};
      burst.bytes[2]  = '{value: col_s[7:0],       is_data: 1'b1, last: 1'b0};
      burst.bytes[3]  = '{value: col_e[15:8],      is_data: 1'b1, last: 1'b0};
      burst.bytes[4]  = '{value: col_e[7:0],       is_data: 1'b1, last: 1'b0};
      burst.bytes[5]  = '{value: CMD_PAGE_ADDR,    is_data: 1'b0, last: 1'b0};
      burst.bytes[6]  = '{value: row_s[15:8],      is_data: 1'b1, last: 1'b0};
      burst.bytes[7]  = '{value: row_s[7:0],       is_data: 1'b1, last: 1'b0};
      burst.bytes[8]  = '{value: row_e[15:8],      is_data: 1'b1, last: 1'b0};
      burst.bytes[9]  = '{value: row_e[7:0],       is_data: 1'b1, last: 1'b0};
      burst.bytes[10] = '{value: CMD_MEMORY_WRITE, is_data: 1'b0, last: 1'b1};
    end

    pix_left_nxt = pix_left_r;
    if (a_move) begin
      if (cmd_r == ITEM_PIXEL) begin
        if (pix_left_r != '0) begin
          pix_left_nxt = pix_left_r - AREA_W'(1);
        end
      end else begin
        // a failed check closes the window
        pix_left_nxt = win_ok ? area_sat : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      pix_left_r <= '0;
    end else begin
      pix_left_r <= pix_left_nxt;
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      xs_r  <= in_x_start;
      ys_r  <= in_y_start;
      xe_r  <= in_x_end;
      ye_r  <= in_y_end;
      pix_r <= in_pixel_rgb565;
    end
  end

  `DWPW_ASSERT(a_fail_no_load, (a_valid_r && cmd_r == ITEM_WINDOW && !win_ok) |-> !burst.load)
  `DWPW_ASSERT(a_drop_no_load, (a_valid_r && cmd_r == ITEM_PIXEL && pix_left_r == '0) |-> !burst.load)
  `DWPW_ASSERT(a_pix_count, (burst.load && cmd_r == ITEM_PIXEL) |=> (pix_left_r == $past(pix_left_r) - AREA_W'(1)))

endmodule

// ===== src/dwpw_serializer.sv =====
// Byte shifter that presents one formatted byte per cycle on the output channel while out_ready is high.
`include "assert_macros.svh"
module dwpw_serializer
  import dwpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dwpw_burst_t burst,
  output logic        ser_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last_of_run
);

  dwpw_byte_t [MAX_BYTES-1:0] bytes_r;
  dwpw_byte_t [MAX_BYTES-1:0] bytes_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;
  logic                       take;

  always_comb begin
    take      = out_valid && out_ready;
    ser_free  = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_ready);
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    priority if (burst.load) begin
      bytes_nxt = burst.bytes;
      cnt_nxt   = burst.count;
    end else if (take) begin
      // advance the queue by one byte
      for (int i = 0; i < MAX_BYTES - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
      end
      bytes_nxt[MAX_BYTES-1] = '0;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_valid       = (cnt_r != '0);
  assign out_byte        = bytes_r[0].value;
  assign out_is_data     = bytes_r[0].is_data;
  assign out_last_of_run = bytes_r[0].last;

  `DWPW_ASSERT(a_load_when_free, burst.load |-> ser_free)
  `DWPW_ASSERT(a_last_matches_count, out_valid |-> (out_last_of_run == (cnt_r == CNT_W'(1))))
  `DWPW_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

// ===== src/display_window_pixel_writer.sv =====
// Display window pixel writer: SPI display byte stream formatter, top level.
// Each accepted item enters an input register; from there its bytes are loaded
// into an 11-entry output shifter when it is free, and the shifter presents
// one byte per cycle while the output is ready. A passing window gives 11 bytes
// (column command, 4 address bytes, page command, 4 address bytes, memory write
// command); a pixel gives 3 bytes. A failed window or a pixel dropped with no
// open window leaves the input register without waiting for the shifter. The
// byte rate of the output shifter sets the throughput; when the shifter is
// free, the first byte of an item is presented on the output once the item has
// passed the input register and been loaded into the shifter. Configuration
// writes take effect at the next clock edge.
module display_window_pixel_writer
  import dwpw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [15:0] in_x_start,
  input  logic signed [15:0] in_y_start,
  input  logic signed [15:0] in_x_end,
  input  logic signed [15:0] in_y_end,
  input  logic [15:0]        in_pixel_rgb565,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_is_data,
  output logic               out_last_of_run
);

  dwpw_cfg_t   cfg;
  dwpw_burst_t burst;
  logic        ser_free;

  dwpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dwpw_format u_format (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_pixel_rgb565 (in_pixel_rgb565),
    .ser_free        (ser_free),
    .burst           (burst)
  );

  dwpw_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .burst           (burst),
    .ser_free        (ser_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_data     (out_is_data),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the display window pixel writer byte stream formatter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic        command;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] pixel_rgb565;
  } draw_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  draw_req_t   cur_req = '{command: ITEM_PIXEL, default: '0};
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_last_of_run;

  logic        in_acc = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          cycle_count = 0;

  // Predictor state: shadow registers and the open window's pixel budget
  logic [10:0] panel_w = PANEL_WIDTH_RST;
  logic [10:0] panel_h = PANEL_HEIGHT_RST;
  logic [15:0] col_off = '0;
  logic [15:0] row_off = '0;
  logic [AREA_W-1:0] open_pixels = '0;

  draw_req_t  pending_reqs[$];
  dwpw_byte_t expected_bytes[$];

  display_window_pixel_writer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (cur_req.command),
    .in_x_start      (cur_req.x_start),
    .in_y_start      (cur_req.y_start),
    .in_x_end        (cur_req.x_end),
    .in_y_end        (cur_req.y_end),
    .in_pixel_rgb565 (cur_req.pixel_rgb565),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_data     (out_is_data),
    .out_last_of_run (out_last_of_run)
  );

  always #1 clk = ~clk;

  function automatic draw_req_t win_req(logic [15:0] xs, logic [15:0] ys,
                                        logic [15:0] xe, logic [15:0] ye);
    draw_req_t r;
    r.command      = ITEM_WINDOW;
    r.x_start      = xs;
    r.y_start      = ys;
    r.x_end        = xe;
    r.y_end        = ye;
    r.pixel_rgb565 = 16'($urandom);
    return r;
  endfunction

  function automatic draw_req_t pix_req(logic [15:0] rgb);
    draw_req_t r;
    r.command      = ITEM_PIXEL;
    r.x_start      = 16'($urandom);
    r.y_start      = 16'($urandom);
    r.x_end        = 16'($urandom);
    r.y_end        = 16'($urandom);
    r.pixel_rgb565 = rgb;
    return r;
  endfunction

  function automatic void push_byte(logic [7:0] v, logic d, logic l);
    expected_bytes.push_back({v, d, l});
  endfunction

  // Expected byte stream of one accepted transaction
  task automatic format_request(input draw_req_t r);
    int xs, ys, xe, ye;
    longint area;
    logic [15:0] xa0, xa1, ya0, ya1;
    logic [4:0] red, blue;
    logic [5:0] green;
    xs = int'($signed(r.x_start));
    ys = int'($signed(r.y_start));
    xe = int'($signed(r.x_end));
    ye = int'($signed(r.y_end));
    if (r.command == ITEM_WINDOW) begin
      if (xe < xs || ye < ys || xs < 0 || ys < 0 ||
          xe >= int'(panel_w) || ye >= int'(panel_h)) begin
        open_pixels = '0;
      end else begin
        xa0 = r.x_start + col_off;
        xa1 = r.x_end + col_off;
        ya0 = r.y_start + row_off;
        ya1 = r.y_end + row_off;
        push_byte(CMD_COLUMN_ADDR, 1'b0, 1'b0);
        push_byte(xa0[15:8], 1'b1, 1'b0);
        push_byte(xa0[7:0], 1'b1, 1'b0);
        push_byte(xa1[15:8], 1'b1, 1'b0);
        push_byte(xa1[7:0], 1'b1, 1'b0);
        push_byte(CMD_PAGE_ADDR, 1'b0, 1'b0);
        push_byte(ya0[15:8], 1'b1, 1'b0);
        push_byte(ya0[7:0], 1'b1, 1'b0);
        push_byte(ya1[15:8], 1'b1, 1'b0);
        push_byte(ya1[7:0], 1'b1, 1'b0);
        push_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1);
        area = longint'(xe - xs + 1) * longint'(ye - ys + 1);
        open_pixels = (area > longint'(COUNT_MAX)) ? COUNT_MAX : area[AREA_W-1:0];
      end
    end else if (open_pixels != '0) begin
      red   = r.pixel_rgb565[15:11];
      green = r.pixel_rgb565[10:5];
      blue  = r.pixel_rgb565[4:0];
      push_byte({red, red[4], 2'b00}, 1'b1, 1'b0);
      push_byte({green, 2'b00}, 1'b1, 1'b0);
      push_byte({blue, blue[4], 2'b00}, 1'b1, 1'b1);
      open_pixels = open_pixels - 1'b1;
    end
  endtask

  // Driver: present the next request at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : monitor
    dwpw_byte_t exp_b;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      format_request(cur_req);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte unexpected: expected none, actual %h", out_byte);
        errors++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_byte !== exp_b.value) begin
          $error("out_byte expected %h actual %h", exp_b.value, out_byte);
          errors++;
        end
        if (out_is_data !== exp_b.is_data) begin
          $error("out_is_data expected %b actual %b", exp_b.is_data, out_is_data);
          errors++;
        end
        if (out_last_of_run !== exp_b.last) begin
          $error("out_last_of_run expected %b actual %b", exp_b.last, out_last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Wait until all requests are taken and all bytes are out, then let the pipe empty
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(dwpw_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PANEL_WIDTH:   panel_w = val[10:0];
      REG_PANEL_HEIGHT:  panel_h = val[10:0];
      REG_COLUMN_OFFSET: col_off = val;
      REG_ROW_OFFSET:    row_off = val;
      default: ;
    endcase
  endtask

  // Mostly windows followed by their pixels, with broken windows and stray pixels
  task automatic gen_traffic(int n);
    int made, kind, w, h, xs, ys, xe, ye, span, npix, v;
    longint area;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99);
      w = int'(panel_w);
      h = int'(panel_h);
      xs = $urandom_range(w - 1);
      ys = $urandom_range(h - 1);
      if ($urandom_range(4) == 0) xs = w - 1;
      if ($urandom_range(4) == 0) ys = h - 1;
      span = w - 1 - xs;
      if (span > 3) span = 3;
      xe = xs + $urandom_range(span);
      span = h - 1 - ys;
      if (span > 2) span = 2;
      ye = ys + $urandom_range(span);
      if (kind < 8) begin
        // stray pixel, dropped unless a window is still open
        pending_reqs.push_back(pix_req(16'($urandom)));
      end else if (kind < 22) begin
        case ($urandom_range(6))
          0: xe = xs - 1;
          1: ye = ys - 1;
          2: xs = -int'($urandom_range(32768, 1));
          3: ys = -int'($urandom_range(32768, 1));
          4: xe = w + $urandom_range(32767 - w);
          5: ye = h + $urandom_range(32767 - h);
          default: begin
            xs = $urandom;
            ys = $urandom;
            xe = $urandom;
            ye = $urandom;
          end
        endcase
        pending_reqs.push_back(win_req(16'(xs), 16'(ys), 16'(xe), 16'(ye)));
        made++;
      end else begin
        if (kind < 30) begin
          // whole panel, only a few pixels before the next window replaces it
          xs = 0;
          ys = 0;
          xe = w - 1;
          ye = h - 1;
          area = longint'(w) * longint'(h);
          npix = $urandom_range(5, 1);
        end else begin
          area = longint'(xe - xs + 1) * longint'(ye - ys + 1);
          v = $urandom_range(9);
          if (v < 6) npix = int'(area);
          else if (v < 8) npix = $urandom_range(int'(area) - 1);
          else npix = int'(area) + int'($urandom_range(2, 1));
        end
        pending_reqs.push_back(win_req(16'(xs), 16'(ys), 16'(xe), 16'(ye)));
        made++;
        for (int i = 0; i < npix; i++) begin
          pending_reqs.push_back(pix_req(16'($urandom)));
          if (i < area) made++;
        end
      end
    end
  endtask

  task automatic run_phase(logic [15:0] w, logic [15:0] h, logic [15:0] co,
                           logic [15:0] ro, int n);
    drain();
    write_reg(REG_PANEL_WIDTH, w);
    write_reg(REG_PANEL_HEIGHT, h);
    write_reg(REG_COLUMN_OFFSET, co);
    write_reg(REG_ROW_OFFSET, ro);
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_traffic(n);
  endtask

  initial begin : stimulus
    send_idle_pct = 9;
    recv_idle_pct = 83;

    // directed part, reset configuration 320 x 480, no offsets
    pending_reqs.push_back(pix_req(16'hffff));              // no open window: dropped
    pending_reqs.push_back(win_req(0, 0, 0, 0));
    pending_reqs.push_back(pix_req(16'hffff));
    pending_reqs.push_back(pix_req(16'h1234));              // budget spent: dropped
    pending_reqs.push_back(win_req(0, 0, 319, 479));
    pending_reqs.push_back(pix_req(16'h0000));
    pending_reqs.push_back(pix_req(16'h8010));
    pending_reqs.push_back(pix_req(16'h7fef));
    pending_reqs.push_back(pix_req(16'hf800));
    pending_reqs.push_back(pix_req(16'h07e0));
    pending_reqs.push_back(pix_req(16'h001f));
    pending_reqs.push_back(win_req(5, 0, 4, 0));            // end before start closes window
    pending_reqs.push_back(pix_req(16'haaaa));
    pending_reqs.push_back(win_req(0, 5, 0, 4));
    pending_reqs.push_back(win_req(16'hffff, 0, 3, 3));     // negative start
    pending_reqs.push_back(win_req(0, 16'h8000, 3, 3));
    pending_reqs.push_back(win_req(0, 0, 320, 0));          // past the panel edge
    pending_reqs.push_back(win_req(0, 0, 0, 480));
    pending_reqs.push_back(win_req(10, 20, 11, 21));
    pending_reqs.push_back(pix_req(16'h5555));
    pending_reqs.push_back(pix_req(16'h0842));
    pending_reqs.push_back(win_req(318, 478, 319, 479));    // replaces the pending count
    for (int i = 0; i < 5; i++) pending_reqs.push_back(pix_req(16'($urandom)));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    run_phase(16'd1, 16'd1, 16'hffff, 16'hffff, 45);
    run_phase(16'd1024, 16'd1024, 16'hfff0, 16'h8000, 45);
    send_idle_pct = 83;
    recv_idle_pct = 9;
    // oversized panel lets the window area saturate the pixel budget
    run_phase(16'd2047, 16'd2047, 16'($urandom), 16'($urandom), 45);
    run_phase(16'($urandom_range(1024, 1)), 16'($urandom_range(1024, 1)),
              16'($urandom), 16'($urandom), 45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'd1024, 16'd1, 16'h0000, 16'hffff, 45);
    run_phase(16'd320, 16'd480, 16'h0000, 16'h0000, 45);
    run_phase(16'($urandom_range(1024, 1)), 16'($urandom_range(1024, 1)),
              16'($urandom), 16'($urandom), 45);
    drain();

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dwpw_pkg.sv
src/dwpw_cfg_regs.sv
src/dwpw_format.sv
src/dwpw_serializer.sv
src/display_window_pixel_writer.sv
tb/sv/tb.sv
